### rtl/core/v2n_pkg.sv
// Package with the shared constants and field widths of the vector normalizer.
package v2n_pkg;

  localparam int FracBitsDefault = 16;
  localparam int InWidth         = 32;
  localparam int CompWidth       = 33;
  localparam int MagWidth        = 33;
  localparam int SqWidth         = 66;
  localparam int UnitWidth       = 18;
  localparam int ThrWidth        = 17;

  localparam logic [ThrWidth-1:0] ThrReset = 17'd1;

  localparam logic signed [UnitWidth-1:0] UnitMax = 18'sd131071;
  localparam logic signed [UnitWidth-1:0] UnitMin = -18'sd131072;

  localparam logic FuncNormalize = 1'b0;
  localparam logic FuncDirection = 1'b1;

endpackage

### rtl/core/vec2_normalize_core.sv
// Top level of the pipelined two-dimensional vector normalizer.
//
// The block takes one request per cycle and returns one result per request, in
// order. The pipe has 5 + MagWidth + 1 + (CompWidth + FRAC_BITS) + 1 stages,
// 89 at FRAC_BITS = 16. Five stages capture the request, form the vector, take
// absolute values, square and sum. The square root then settles one result bit
// per stage, one stage compares the magnitude against the threshold, the two
// restoring dividers run side by side and settle one quotient bit per stage,
// and a last stage applies the sign and saturates. The whole pipe advances
// together: when the output is stalled and the last stage holds a result,
// every stage holds and the input is stalled in the same cycle, so nothing is
// lost or repeated. Empty stages are not squeezed out; a bubble moves along
// with the rest of the pipe. While the output is not stalled a request can
// enter in every cycle. The zero threshold is sampled per request at entry, so
// it may be written at any time that the pipe is empty.
module vec2_normalize_core
  import v2n_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic signed [InWidth-1:0]   ax,
  input  logic signed [InWidth-1:0]   ay,
  input  logic signed [InWidth-1:0]   bx,
  input  logic signed [InWidth-1:0]   by,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [UnitWidth-1:0] unit_x,
  output logic signed [UnitWidth-1:0] unit_y,
  output logic [MagWidth-1:0]         length,
  output logic                        was_zero,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ThrWidth-1:0]         cfg_data
);

  // Dividend width: |component| shifted left by FRAC_BITS.
  localparam int DivWidth = CompWidth + FRAC_BITS;
  // Square root stages: one per result bit, msb first.
  localparam int SqrtSteps = MagWidth;
  // Division stages: one per quotient bit.
  localparam int DivSteps = DivWidth;
  // Total stage count: entry, difference, abs, square, sum,
  // sqrt, decide, div, saturate.
  localparam int NStages = 5 + SqrtSteps + 1 + DivSteps + 1;
  localparam int RemWidth = MagWidth + 1;

  // Flow control: one global advance, pipe moves as a whole when the output
  // end is free. Bubbles travel along with the pipe.
  logic advance;
  logic [NStages-1:0] vld;

  assign advance   = !(vld[NStages-1] && out_stall);
  assign in_stall  = !advance;
  assign out_valid = vld[NStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NStages-2:0], in_valid};
    end
  end

  // Configuration register.
  logic [ThrWidth-1:0] zero_threshold;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= ThrReset;
    end else if (cfg_valid) begin
      zero_threshold <= cfg_data;
    end
  end

  // Stage 0: capture the request.
  logic                      s0_func;
  logic signed [InWidth-1:0] s0_ax, s0_ay, s0_bx, s0_by;
  logic [ThrWidth-1:0]       s0_thr;
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_func <= func;
      s0_ax   <= ax;
      s0_ay   <= ay;
      s0_bx   <= bx;
      s0_by   <= by;
      s0_thr  <= zero_threshold;
    end
  end

  // Stage 1: form the vector at 33 bits.
  logic signed [CompWidth-1:0] s1_x, s1_y;
  logic [ThrWidth-1:0]         s1_thr;
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_thr <= s0_thr;
      if (s0_func == FuncDirection) begin
        s1_x <= CompWidth'(s0_bx) - CompWidth'(s0_ax);
        s1_y <= CompWidth'(s0_by) - CompWidth'(s0_ay);
      end else begin
        s1_x <= CompWidth'(s0_ax);
        s1_y <= CompWidth'(s0_ay);
      end
    end
  end

  // Stage 2: absolute values.
  logic signed [CompWidth-1:0] s2_x, s2_y;
  logic [CompWidth-1:0]        s2_ux, s2_uy;
  logic [ThrWidth-1:0]         s2_thr;
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      s2_thr <= s1_thr;
      s2_ux  <= s1_x[CompWidth-1] ? CompWidth'(-s1_x) : CompWidth'(s1_x);
      s2_uy  <= s1_y[CompWidth-1] ? CompWidth'(-s1_y) : CompWidth'(s1_y);
    end
  end

  // Stage 3: squares. Each is a 33x33 product; synthesis splits it across
  // DSP slices and the result is registered before the sum.
  logic signed [CompWidth-1:0] s3_x, s3_y;
  logic [SqWidth-1:0]          s3_sx, s3_sy;
  logic [ThrWidth-1:0]         s3_thr;
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_x   <= s2_x;
      s3_y   <= s2_y;
      s3_thr <= s2_thr;
      s3_sx  <= SqWidth'(s2_ux) * SqWidth'(s2_ux);
      s3_sy  <= SqWidth'(s2_uy) * SqWidth'(s2_uy);
    end
  end

  // Stage 4: sum of squares, 67 bits wide so the carry is kept.
  logic signed [CompWidth-1:0] s4_x, s4_y;
  logic [SqWidth:0]            s4_sum;
  logic [ThrWidth-1:0]         s4_thr;
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_x   <= s3_x;
      s4_y   <= s3_y;
      s4_thr <= s3_thr;
      s4_sum <= (SqWidth+1)'(s3_sx) + (SqWidth+1)'(s3_sy);
    end
  end

  // Square root: restoring digit recurrence, one result bit a stage.
  // Each stage consumes two bits of the radicand.
  localparam int RadWidth = 2 * SqrtSteps;
  localparam int SRemW    = SqrtSteps + 2;

  logic signed [CompWidth-1:0] sq_x   [SqrtSteps+1];
  logic signed [CompWidth-1:0] sq_y   [SqrtSteps+1];
  logic [ThrWidth-1:0]         sq_thr [SqrtSteps+1];
  logic [RadWidth-1:0]         sq_rad [SqrtSteps+1];
  logic [SRemW-1:0]            sq_rem [SqrtSteps+1];
  logic [SqrtSteps-1:0]        sq_root[SqrtSteps+1];

  assign sq_x[0]    = s4_x;
  assign sq_y[0]    = s4_y;
  assign sq_thr[0]  = s4_thr;
  assign sq_rad[0]  = RadWidth'(s4_sum);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [SRemW-1:0]     rem_sh;
    logic [SRemW-1:0]     trial;
    logic                 take;
    always_comb begin
      rem_sh = {sq_rem[i][SRemW-3:0], sq_rad[i][RadWidth-1 -: 2]};
      trial  = {sq_root[i], 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        sq_x[i+1]    <= sq_x[i];
        sq_y[i+1]    <= sq_y[i];
        sq_thr[i+1]  <= sq_thr[i];
        sq_rad[i+1]  <= {sq_rad[i][RadWidth-3:0], 2'b00};
        sq_rem[i+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root[i+1] <= {sq_root[i][SqrtSteps-2:0], take};
      end
    end
  end

  // Decide stage: compare against threshold and set up the dividers.
  logic signed [CompWidth-1:0] d_x, d_y;
  logic [MagWidth-1:0]         d_mag;
  logic                        d_zero;
  always_ff @(posedge clk) begin
    if (advance) begin
      d_x    <= sq_x[SqrtSteps];
      d_y    <= sq_y[SqrtSteps];
      d_mag  <= MagWidth'(sq_root[SqrtSteps]);
      d_zero <= (sq_root[SqrtSteps] == '0) ||
                (MagWidth'(sq_root[SqrtSteps]) < MagWidth'(sq_thr[SqrtSteps]));
    end
  end

  // Restoring dividers, one quotient bit per stage for both components.
  logic signed [CompWidth-1:0] dv_x   [DivSteps+1];
  logic signed [CompWidth-1:0] dv_y   [DivSteps+1];
  logic [MagWidth-1:0]         dv_mag [DivSteps+1];
  logic                        dv_zero[DivSteps+1];
  logic [DivWidth-1:0]         dv_nx  [DivSteps+1];
  logic [DivWidth-1:0]         dv_ny  [DivSteps+1];
  logic [RemWidth-1:0]         dv_rx  [DivSteps+1];
  logic [RemWidth-1:0]         dv_ry  [DivSteps+1];

  assign dv_x[0]    = d_x;
  assign dv_y[0]    = d_y;
  assign dv_mag[0]  = d_mag;
  assign dv_zero[0] = d_zero;
  assign dv_nx[0]   = {(d_x[CompWidth-1] ? CompWidth'(-d_x) : CompWidth'(d_x)),
                       {FRAC_BITS{1'b0}}};
  assign dv_ny[0]   = {(d_y[CompWidth-1] ? CompWidth'(-d_y) : CompWidth'(d_y)),
                       {FRAC_BITS{1'b0}}};
  assign dv_rx[0]   = '0;
  assign dv_ry[0]   = '0;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [RemWidth-1:0] px, py;
    logic                tx, ty;
    always_comb begin
      px = {dv_rx[i][RemWidth-2:0], dv_nx[i][DivWidth-1]};
      py = {dv_ry[i][RemWidth-2:0], dv_ny[i][DivWidth-1]};
      tx = px >= {1'b0, dv_mag[i]};
      ty = py >= {1'b0, dv_mag[i]};
    end
    // The dividend shifts out at the top and the quotient bits enter below.
    always_ff @(posedge clk) begin
      if (advance) begin
        dv_x[i+1]    <= dv_x[i];
        dv_y[i+1]    <= dv_y[i];
        dv_mag[i+1]  <= dv_mag[i];
        dv_zero[i+1] <= dv_zero[i];
        dv_rx[i+1]   <= tx ? px - {1'b0, dv_mag[i]} : px;
        dv_ry[i+1]   <= ty ? py - {1'b0, dv_mag[i]} : py;
        dv_nx[i+1]   <= {dv_nx[i][DivWidth-2:0], tx};
        dv_ny[i+1]   <= {dv_ny[i][DivWidth-2:0], ty};
      end
    end
  end

  // Final stage: sign, saturate, or pass through.
  function automatic logic signed [UnitWidth-1:0] sat_q(
    input logic [DivWidth-1:0] q, input logic neg);
    logic big;
    big = (q > DivWidth'(131071));
    if (neg) begin
      sat_q = (q > DivWidth'(131072)) ? UnitMin : UnitWidth'(-q);
    end else begin
      sat_q = big ? UnitMax : UnitWidth'(q);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (advance) begin
      length   <= dv_mag[DivSteps];
      was_zero <= dv_zero[DivSteps];
      if (dv_zero[DivSteps]) begin
        unit_x <= UnitWidth'(dv_x[DivSteps]);
        unit_y <= UnitWidth'(dv_y[DivSteps]);
      end else begin
        unit_x <= sat_q(dv_nx[DivSteps], dv_x[DivSteps][CompWidth-1]);
        unit_y <= sat_q(dv_ny[DivSteps], dv_y[DivSteps][CompWidth-1]);
      end
    end
  end

`ifndef SYNTH
  // A stalled result keeps its length and flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(length) && $stable(was_zero))
    else $error("result changed while stalled");
  // The input is stalled only when the output holds a stalled result.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  // The x component of a normalized result never exceeds one in magnitude when FRAC_BITS is at most 16.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_zero && FRAC_BITS <= 16 |->
      unit_x <= UnitWidth'(1 << FRAC_BITS) && unit_x >= -UnitWidth'(1 << FRAC_BITS))
    else $error("unit component out of range");
`endif

endmodule
